### sv/vwtc_pkg.sv
// ============================================================================
// vwtc_pkg - shared types and constants of the voxel window classifier
// Field widths, register indexes, decision reasons, sequencer states and
// the structs passed between the accumulator, multiplier and controller.
// ============================================================================
package vwtc_pkg;

    localparam int VALUE_W    = 8;
    localparam int DEPTH_W    = 15;
    localparam int SUM_W      = 15;
    localparam int CNT_W      = 7;
    localparam int THR_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = THR_W + SUM_W;   // threshold times removed sum
    localparam int MUL_B_W = THR_W;
    localparam int PROD_W  = MUL_A_W + CNT_W; // that product times a count
    localparam int LHS_W   = SUM_W + CNT_W;   // remaining sum times removed count

    localparam logic [SUM_W-1:0]   SUM_MAX       = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX       = '1;
    localparam logic [DEPTH_W-1:0] SHALLOW_DEPTH = DEPTH_W'(25);

    localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(768);
    localparam logic [VALUE_W-1:0] LOW_RESET  = VALUE_W'(0);
    localparam logic [VALUE_W-1:0] HIGH_RESET = VALUE_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATIO_THRESHOLD = 2'd0,
        REG_GREY_LOW        = 2'd1,
        REG_GREY_HIGH       = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        RSN_SHALLOW      = 3'd0,
        RSN_BELOW_LOW    = 3'd1,
        RSN_ABOVE_HIGH   = 3'd2,
        RSN_FEW_REMOVED  = 3'd3,
        RSN_NOT_BRIGHTER = 3'd4,
        RSN_MEAN_LOW     = 3'd5,
        RSN_RATIO_LOW    = 3'd6,
        RSN_RATIO_OK     = 3'd7
    } reason_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BRIGHT,
        ST_MUL_THR,
        ST_MUL_LHS,
        ST_MUL_RHS,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [THR_W-1:0]   ratio_threshold;
        logic [VALUE_W-1:0] grey_low;
        logic [VALUE_W-1:0] grey_high;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] removed_sum;
        logic [CNT_W-1:0] removed_count;
        logic [SUM_W-1:0] remaining_sum;
        logic [CNT_W-1:0] remaining_count;
    } win_t;

    typedef struct packed {
        logic acc_en;
        logic clear;
    } acc_ctl_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

### sv/vwtc_accum.sv
// ============================================================================
// vwtc_accum - window sums and counts
// Adds each nonzero window voxel to the removed or remaining sum and count,
// saturating, and clears all four at the end of a window.
// ============================================================================
module vwtc_accum
    import vwtc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  acc_ctl_t           ctl,
    input  logic [VALUE_W-1:0] neighbor_value,
    input  logic               neighbor_removed,
    output win_t               win
);

    logic [SUM_W-1:0] rm_sum_reg,  rm_sum_next;
    logic [CNT_W-1:0] rm_cnt_reg,  rm_cnt_next;
    logic [SUM_W-1:0] rem_sum_reg, rem_sum_next;
    logic [CNT_W-1:0] rem_cnt_reg, rem_cnt_next;

    logic [SUM_W:0]   sum_in;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic [CNT_W-1:0] cnt_in;
    logic [CNT_W-1:0] cnt_sat;

    // Select the side this voxel feeds, then saturate the add
    always_comb
    begin
        sum_in   = neighbor_removed ? {1'b0, rm_sum_reg} : {1'b0, rem_sum_reg};
        cnt_in   = neighbor_removed ? rm_cnt_reg : rem_cnt_reg;
        sum_wide = sum_in + (SUM_W + 1)'(neighbor_value);
        sum_sat  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
        cnt_sat  = (cnt_in == CNT_MAX) ? CNT_MAX : cnt_in + CNT_W'(1);
    end

    // Next values: clear at end of window, else update one side
    always_comb
    begin
        rm_sum_next  = rm_sum_reg;
        rm_cnt_next  = rm_cnt_reg;
        rem_sum_next = rem_sum_reg;
        rem_cnt_next = rem_cnt_reg;
        if (ctl.clear)
        begin
            rm_sum_next  = '0;
            rm_cnt_next  = '0;
            rem_sum_next = '0;
            rem_cnt_next = '0;
        end
        else if (ctl.acc_en && (neighbor_value != '0))
        begin
            if (neighbor_removed)
            begin
                rm_sum_next = sum_sat;
                rm_cnt_next = cnt_sat;
            end
            else
            begin
                rem_sum_next = sum_sat;
                rem_cnt_next = cnt_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rm_sum_reg  <= '0;
            rm_cnt_reg  <= '0;
            rem_sum_reg <= '0;
            rem_cnt_reg <= '0;
        end
        else
        begin
            rm_sum_reg  <= rm_sum_next;
            rm_cnt_reg  <= rm_cnt_next;
            rem_sum_reg <= rem_sum_next;
            rem_cnt_reg <= rem_cnt_next;
        end
    end

    assign win.removed_sum     = rm_sum_reg;
    assign win.removed_count   = rm_cnt_reg;
    assign win.remaining_sum   = rem_sum_reg;
    assign win.remaining_count = rem_cnt_reg;

    // A clear empties the window
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (rm_cnt_reg == '0 && rem_cnt_reg == '0
                       && rm_sum_reg == '0 && rem_sum_reg == '0))
        else $error("window state not cleared");

    // Every counted voxel is at least 1, so a sum never falls below its count
    a_sum_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(rm_cnt_reg) <= rm_sum_reg) && (SUM_W'(rem_cnt_reg) <= rem_sum_reg))
        else $error("sum below count");

endmodule

### sv/vwtc_mulu.sv
// ============================================================================
// vwtc_mulu - shared multiplier
// One unsigned multiplier with a registered product, reused by the
// controller for every cross-multiplication of the decision.
// ============================================================================
module vwtc_mulu
    import vwtc_pkg::*;
(
    input  logic              clk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [MUL_A_W+MUL_B_W-1:0] full;
    logic [PROD_W-1:0]          prod_reg;

    // Multiply; operands are chosen so the product fits in PROD_W bits
    assign full = req.a * req.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

    assign prod = prod_reg;

endmodule

### sv/vwtc_ctrl.sv
// ============================================================================
// vwtc_ctrl - window sequencer and decision logic
// Accepts window voxels, and on the last one steps the shared multiplier
// through the mean tests, then forms the grey/white decision and its reason.
// ============================================================================
module vwtc_ctrl
    import vwtc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last_in_window,
    input  logic [VALUE_W-1:0] center_value,
    input  logic [DEPTH_W-1:0] center_depth,
    input  cfg_t               cfg,
    input  win_t               win,
    input  logic [PROD_W-1:0]  prod,
    output acc_ctl_t           acc_ctl,
    output mul_req_t           mul_req,
    output logic               busy,
    output logic               done,
    output logic               is_white,
    output logic [2:0]         decision_reason
);

    state_t             state_reg, state_next;
    logic               done_reg, done_next;
    reason_t            reason_reg, reason_next;
    logic               white_reg, white_next;
    logic [VALUE_W-1:0] u_reg, u_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               not_brighter_reg, not_brighter_next;
    logic [MUL_A_W-1:0] thr_prod_reg, thr_prod_next;
    logic [LHS_W-1:0]   lhs_reg, lhs_next;

    logic accept;
    logic few_remaining;
    logic ratio_low;

    assign accept        = start && (state_reg == ST_IDLE);
    assign few_remaining = (win.remaining_count <= CNT_W'(1));
    assign ratio_low     = {{(PROD_W - LHS_W - 8){1'b0}}, lhs_reg, 8'b0} < prod;

    // Next state, multiplier operands and decision
    always_comb
    begin
        state_next        = state_reg;
        done_next         = 1'b0;
        reason_next       = reason_reg;
        white_next        = white_reg;
        u_next            = u_reg;
        depth_next        = depth_reg;
        not_brighter_next = not_brighter_reg;
        thr_prod_next     = thr_prod_reg;
        lhs_next          = lhs_reg;
        acc_ctl.acc_en    = 1'b0;
        acc_ctl.clear     = 1'b0;
        mul_req.a         = '0;
        mul_req.b         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                acc_ctl.acc_en = accept;
                if (accept && last_in_window)
                begin
                    u_next     = center_value;
                    depth_next = center_depth;
                    state_next = ST_MUL_BRIGHT;
                end
            end
            ST_MUL_BRIGHT:
            begin
                // center times removed count
                mul_req.a  = MUL_A_W'(u_reg);
                mul_req.b  = MUL_B_W'(win.removed_count);
                state_next = ST_MUL_THR;
            end
            ST_MUL_THR:
            begin
                // threshold times removed sum; keep the brightness test
                mul_req.a         = MUL_A_W'(win.removed_sum);
                mul_req.b         = cfg.ratio_threshold;
                not_brighter_next = (prod <= PROD_W'(win.removed_sum));
                state_next        = ST_MUL_LHS;
            end
            ST_MUL_LHS:
            begin
                // remaining mean side; fall back to the center value
                mul_req.a     = few_remaining ? MUL_A_W'(u_reg)
                                              : MUL_A_W'(win.remaining_sum);
                mul_req.b     = MUL_B_W'(win.removed_count);
                thr_prod_next = prod[MUL_A_W-1:0];
                state_next    = ST_MUL_RHS;
            end
            ST_MUL_RHS:
            begin
                // scale the threshold product by the remaining count
                mul_req.a  = thr_prod_reg;
                mul_req.b  = few_remaining ? MUL_B_W'(1) : MUL_B_W'(win.remaining_count);
                lhs_next   = prod[LHS_W-1:0];
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // first matching check decides
                if (depth_reg < SHALLOW_DEPTH)
                    reason_next = RSN_SHALLOW;
                else if (u_reg < cfg.grey_low)
                    reason_next = RSN_BELOW_LOW;
                else if (u_reg > cfg.grey_high)
                    reason_next = RSN_ABOVE_HIGH;
                else if (win.removed_count <= CNT_W'(1))
                    reason_next = RSN_FEW_REMOVED;
                else if (not_brighter_reg)
                    reason_next = RSN_NOT_BRIGHTER;
                else if (win.removed_sum < SUM_W'(win.removed_count))
                    reason_next = RSN_MEAN_LOW;
                else if (ratio_low)
                    reason_next = RSN_RATIO_LOW;
                else
                    reason_next = RSN_RATIO_OK;
                white_next    = (reason_next == RSN_ABOVE_HIGH)
                              || (reason_next == RSN_RATIO_OK);
                done_next     = 1'b1;
                acc_ctl.clear = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        reason_reg       <= reason_next;
        white_reg        <= white_next;
        u_reg            <= u_next;
        depth_reg        <= depth_next;
        not_brighter_reg <= not_brighter_next;
        thr_prod_reg     <= thr_prod_next;
        lhs_reg          <= lhs_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign is_white        = white_reg;
    assign decision_reason = reason_reg;

    // A decision always produces a result on the next cycle
    a_decide_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |=> done_reg)
        else $error("decision without result");

    // The sequence runs straight through to the decision
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_BRIGHT) |-> ##4 (state_reg == ST_DECIDE))
        else $error("sequencer skipped a step");

    // Results are single-cycle strobes, separated by a full sequence
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("repeated result strobe");

    // White exactly for the two white reasons
    a_white_reason: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (white_reg == ((reason_reg == RSN_ABOVE_HIGH)
                                    || (reason_reg == RSN_RATIO_OK))))
        else $error("color disagrees with reason");

endmodule

### sv/voxel_window_tissue_classifier_top.sv
// ============================================================================
// voxel_window_tissue_classifier_top - grey/white voxel classifier
// Accumulates a window of voxels and classifies the center voxel.
// ============================================================================
// Send the window voxels one per request with start; each is taken when
// start is high and busy is low. An ordinary voxel leaves busy low. The
// voxel marked last_in_window holds busy high while one shared multiplier
// works through the four cross-multiplications of the mean tests and the
// decision is formed. The result appears on is_white and decision_reason
// for exactly one cycle with done high, in the cycle busy falls; the
// receiver cannot stall it, and the next window may start in that same
// cycle. Configuration registers must be written with cfg_we only while
// the block is not busy; the block itself does not enforce this.
// ============================================================================
module voxel_window_tissue_classifier_top
    import vwtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_W-1:0]    center_value,
    input  logic [DEPTH_W-1:0]    center_depth,
    input  logic [VALUE_W-1:0]    neighbor_value,
    input  logic                  neighbor_removed,
    input  logic                  last_in_window,
    output logic                  done,
    output logic                  is_white,
    output logic [2:0]            decision_reason
);

    logic [THR_W-1:0]   ratio_threshold_reg;
    logic [VALUE_W-1:0] grey_low_reg;
    logic [VALUE_W-1:0] grey_high_reg;

    cfg_t              cfg;
    win_t              win;
    acc_ctl_t          acc_ctl;
    mul_req_t          mul_req;
    logic [PROD_W-1:0] prod;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_threshold_reg <= THR_RESET;
            grey_low_reg        <= LOW_RESET;
            grey_high_reg       <= HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RATIO_THRESHOLD: ratio_threshold_reg <= cfg_data[THR_W-1:0];
                REG_GREY_LOW:        grey_low_reg        <= cfg_data[VALUE_W-1:0];
                REG_GREY_HIGH:       grey_high_reg       <= cfg_data[VALUE_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.ratio_threshold = ratio_threshold_reg;
    assign cfg.grey_low        = grey_low_reg;
    assign cfg.grey_high       = grey_high_reg;

    vwtc_accum u_accum
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (acc_ctl),
        .neighbor_value   (neighbor_value),
        .neighbor_removed (neighbor_removed),
        .win              (win)
    );

    vwtc_mulu u_mulu
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    vwtc_ctrl u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .last_in_window  (last_in_window),
        .center_value    (center_value),
        .center_depth    (center_depth),
        .cfg             (cfg),
        .win             (win),
        .prod            (prod),
        .acc_ctl         (acc_ctl),
        .mul_req         (mul_req),
        .busy            (busy),
        .done            (done),
        .is_white        (is_white),
        .decision_reason (decision_reason)
    );

endmodule
